FILE: hw/rtl/stbs_pkg.sv
// Shared types and constants for the sorted-table binary search block.
// No dependencies; used by every module under hw/rtl.
`timescale 1ns / 1ps

package stbs_pkg;

	localparam int DEF_TABLE_DEPTH = 1024;
	localparam int DEF_VALUE_BITS  = 32;
	localparam int FIELD_BITS      = 32;
	localparam int INDEX_BITS      = 10;
	localparam int POS_BITS        = 10;
	localparam int USED_BITS       = 11;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef struct packed {
		logic                         opcode;
		logic [INDEX_BITS-1:0]        entry_index;
		logic signed [FIELD_BITS-1:0] entry_value;
		logic signed [FIELD_BITS-1:0] search_key;
	} in_item_t;

	typedef struct packed {
		logic                found;
		logic [POS_BITS-1:0] position;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic wr;       // table write transfer
		logic start;    // search transfer, load key and bounds
		logic probe;    // read table at mid, or record miss when range is empty
		logic cmp;      // compare read entry and narrow the range
		logic load_out; // move result into output register
	} ctl_cmd_t;

	typedef struct packed {
		logic range_empty;
		logic hit;
		logic out_free;
	} dp_status_t;

endpackage

FILE: hw/rtl/sorted_table_binary_search_top.sv
// Top level of the sorted-table binary search block.
// Depends on stbs_pkg, stbs_ctrl and stbs_datapath.
`timescale 1ns / 1ps

// Holds TABLE_DEPTH signed entries of VALUE_BITS, kept sorted ascending by the
// user; the first used_entries (set through cfg_wr_en/cfg_wr_data) are searched.
// A write transfer gives no result. A search transfer makes p probes,
// p <= ceil(log2(n + 1)), and ends on a hit or when the range is empty; each
// probe is one read of the table memory and one compare. The block is ready
// for the next input in the same cycle in which the result appears. Inputs
// are taken only between searches; a finished result waits in the output
// register, and the next item is taken while it waits unless a second search
// completes before the first result is collected.

module sorted_table_binary_search_top
	import stbs_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_wr_en,
	input  logic [USED_BITS-1:0] cfg_wr_data
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	stbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_opcode (in_data.opcode),
		.in_ready  (in_ready),
		.status    (status),
		.cmd       (cmd)
	);

	stbs_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_BITS  (VALUE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

FILE: hw/rtl/stbs_ctrl.sv
// Search sequencer: state machine issuing commands to the datapath.
// Depends on stbs_pkg.
`timescale 1ns / 1ps

module stbs_ctrl
	import stbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_opcode,
	output logic       in_ready,
	input  dp_status_t status,
	output ctl_cmd_t   cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_opcode == OP_SEARCH) begin
					state_nxt = ST_PROBE;
				end
			end
			ST_PROBE: begin
				state_nxt = status.range_empty ? ST_FINISH : ST_CMP;
			end
			ST_CMP: begin
				state_nxt = status.hit ? ST_FINISH : ST_PROBE;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.wr    = in_valid && in_opcode == OP_WRITE;
				cmd.start = in_valid && in_opcode == OP_SEARCH;
			end
			ST_PROBE: begin
				cmd.probe = 1'b1;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
			end
			ST_FINISH: begin
				cmd.load_out = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

FILE: hw/rtl/stbs_datapath.sv
// Table memory, search bounds, compare and output register.
// Depends on stbs_pkg; driven by stbs_ctrl commands.
`timescale 1ns / 1ps

module stbs_datapath
	import stbs_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  in_item_t             in_data,
	input  logic                 cfg_wr_en,
	input  logic [USED_BITS-1:0] cfg_wr_data,
	input  ctl_cmd_t             cmd,
	output dp_status_t           status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int NW = $clog2(TABLE_DEPTH + 1);

	logic signed [VALUE_BITS-1:0] table_mem [TABLE_DEPTH];
	logic signed [VALUE_BITS-1:0] rdata_q;
	logic signed [VALUE_BITS-1:0] key_q;
	logic signed [VALUE_BITS-1:0] wr_value;
	logic signed [VALUE_BITS-1:0] in_key;

	logic [USED_BITS-1:0] used_q;
	logic [NW-1:0]        live_n;
	logic [NW-1:0]        low_q, hi_q;   // hi_q is one past the upper bound
	logic [NW:0]          mid_sum;
	logic [AW-1:0]        mid, mid_q;
	logic                 wr_in_range;
	logic                 res_found_q;
	logic [POS_BITS-1:0]  res_pos_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	if (VALUE_BITS > FIELD_BITS) begin : g_wide
		assign wr_value = {{(VALUE_BITS-FIELD_BITS){in_data.entry_value[FIELD_BITS-1]}},
			in_data.entry_value};
		assign in_key   = {{(VALUE_BITS-FIELD_BITS){in_data.search_key[FIELD_BITS-1]}},
			in_data.search_key};
	end else begin : g_narrow
		assign wr_value = in_data.entry_value[VALUE_BITS-1:0];
		assign in_key   = in_data.search_key[VALUE_BITS-1:0];
	end

	assign live_n      = (32'(used_q) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(used_q);
	assign wr_in_range = 32'(in_data.entry_index) < TABLE_DEPTH;
	assign mid_sum     = (NW+1)'(low_q) + (NW+1)'(hi_q) - (NW+1)'(1);
	assign mid         = AW'(mid_sum >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cfg_wr_en) begin
			used_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && wr_in_range) begin
			table_mem[AW'(in_data.entry_index)] <= wr_value;
		end
		rdata_q <= table_mem[mid];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= in_key;
			low_q <= '0;
			hi_q  <= live_n;
		end
		if (cmd.probe) begin
			mid_q <= mid;
			if (low_q >= hi_q) begin
				res_found_q <= 1'b0;
				res_pos_q   <= '0;
			end
		end
		if (cmd.cmp) begin
			if (key_q == rdata_q) begin
				res_found_q <= 1'b1;
				res_pos_q   <= POS_BITS'(mid_q);
			end else if (key_q > rdata_q) begin
				low_q <= NW'(mid_q) + NW'(1);
			end else begin
				hi_q <= NW'(mid_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.found    <= res_found_q;
			out_q.position <= res_pos_q;
		end
	end

	assign status.range_empty = low_q >= hi_q;
	assign status.hit         = key_q == rdata_q;
	assign status.out_free    = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
